// ===== src/cdf_pkg.sv =====
// Package for the normal CDF core: Q30 fixed-point widths, constants and
// polynomial coefficients shared by all pipeline modules.
// Depends on nothing.
`default_nettype none

package cdf_pkg;

	// Field and parameter defaults.
	localparam int X_W                 = 16;
	localparam int DEF_INPUT_FRAC_BITS = 12;
	localparam int DEF_OUTPUT_BITS     = 16;

	// Internal Q30 arithmetic.
	localparam int QF     = 30;
	localparam int MAG_W  = X_W + 1;
	localparam int CINV_W = 30;
	localparam int ZP_W   = MAG_W + CINV_W;
	localparam int Z_W    = 33;
	localparam int CP_W   = 29;
	localparam int PZ_W   = CP_W + Z_W;
	localparam int D_W    = 32;
	localparam int T_W    = 31;
	localparam int ZQ_W   = 27;
	localparam int ZZ_W   = 2 * ZQ_W;
	localparam int ACC_W  = 33;
	localparam int PA_W   = 32;
	localparam int E_W    = 31;
	localparam int G_W    = 30;

	localparam int POLY_STEPS   = 5;
	localparam int TAYLOR_TERMS = 10;
	localparam int SQUARINGS    = 5;

	localparam logic [CINV_W-1:0] C_INV_SQRT2 = 30'd759250125;
	localparam logic [CP_W-1:0]   C_P         = 29'd351748265;
	localparam logic [QF-1:0]     RND_Q       = 30'h2000_0000;
	localparam logic [E_W-1:0]    ONE_Q       = 31'h4000_0000;
	localparam logic [Z_W-1:0]    Z_MAX       = 33'h1_8000_0000;

	// Horner coefficients: the leading one, then what each step adds.
	localparam logic signed [ACC_W-1:0] POLY_A5 = 33'sd1139675401;
	localparam logic signed [ACC_W-1:0] POLY_ADD [POLY_STEPS] = '{
		-33'sd1560310108,
		33'sd1526231383,
		-33'sd305476044,
		33'sd273621191,
		33'sd0
	};

endpackage

`default_nettype wire

// ===== src/cdf_in_if.sv =====
// Input channel of the normal CDF core: one signed Q4.12 score per item.
// Depends on cdf_pkg.
`default_nettype none

interface cdf_in_if import cdf_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic signed [X_W-1:0] x_value;

	modport source (output valid, output x_value, input ready);
	modport sink (input valid, input x_value, output ready);
endinterface

`default_nettype wire

// ===== src/cdf_out_if.sv =====
// Output channel of the normal CDF core: one unsigned probability per item.
// Depends on cdf_pkg.
`default_nettype none

interface cdf_out_if import cdf_pkg::*; #(
	parameter int OUTPUT_BITS = DEF_OUTPUT_BITS
);
	logic                   valid;
	logic                   ready;
	logic [OUTPUT_BITS-1:0] probability;

	modport source (output valid, output probability, input ready);
	modport sink (input valid, input probability, output ready);
endinterface

`default_nettype wire

// ===== src/normal_cdf_approximation_core.sv =====
// Top level of the normal CDF core (Abramowitz-Stegun 7.1.26 in Q30 fixed point).
// Depends on cdf_pkg, cdf_in_if, cdf_out_if, cdf_recip, cdf_poly and cdf_exp.
//
//   channel  direction  payload                      meaning
//   sample   in         x_value[15:0], signed        standard score, Q4.12
//   result   out        probability[OB-1:0]          Phi(x), Q0.OB, saturated
//
// One item enters per cycle while the pipeline is not stalled. From acceptance
// to result, an item passes three front stages, the 31-stage divider, the ten
// Horner stages, the 37-stage exponential unit and two back stages.
// Reset clears only the valid bits; the payload registers carry no reset.
// The whole pipeline advances when the output register is empty or taken, so
// a stall holds every stage in place and no item is lost or repeated.
`default_nettype none

module normal_cdf_approximation_core import cdf_pkg::*; #(
	parameter int INPUT_FRAC_BITS = DEF_INPUT_FRAC_BITS,
	parameter int OUTPUT_BITS     = DEF_OUTPUT_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	cdf_in_if.sink     sample,
	cdf_out_if.source  result
);

	localparam int CZ_W = PZ_W;
	localparam int MP_W = PA_W + E_W;
	localparam logic [31:0] TOP_CODE  = (32'd1 << OUTPUT_BITS) - 32'd1;
	localparam logic [31:0] HALF_CODE = 32'd1 << (OUTPUT_BITS - 1);

	logic en;

	// Front stage 1: magnitude times 1/sqrt(2).
	logic [MAG_W-1:0] mag;
	logic             v_s1;
	logic [ZP_W-1:0]  zp_s1;
	logic             neg_s1;

	assign mag = sample.x_value[X_W-1] ?
		(MAG_W'(1) << X_W) - {1'b0, sample.x_value} : {1'b0, sample.x_value};

	// Front stage 2: round and clamp z, multiply by p.
	logic [ZP_W-1:0] zr;
	logic [Z_W-1:0]  z;
	logic            v_s2;
	logic [CZ_W-1:0] pz_s2;
	logic [Z_W-1:0]  z_s2;
	logic            neg_s2;

	assign zr = (zp_s1 + (ZP_W'(1) << (INPUT_FRAC_BITS - 1))) >> INPUT_FRAC_BITS;
	assign z  = (zr > ZP_W'(Z_MAX)) ? Z_MAX : zr[Z_W-1:0];

	// Front stage 3: divisor d and the square of z rounded to Q24.
	logic [CZ_W-1:0] pzsum;
	logic [Z_W-1:0]  zsum;
	logic [ZQ_W-1:0] z24;
	logic            v_s3;
	logic [D_W-1:0]  d_s3;
	logic [ZZ_W-1:0] zz_s3;
	logic            neg_s3;

	assign pzsum = pz_s2 + CZ_W'(RND_Q);
	assign zsum  = z_s2 + Z_W'(32);
	assign z24   = ZQ_W'(zsum >> 6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zp_s1  <= ZP_W'(mag * C_INV_SQRT2);
			neg_s1 <= sample.x_value[X_W-1];
			pz_s2  <= CZ_W'(C_P * z);
			z_s2   <= z;
			neg_s2 <= neg_s1;
			d_s3   <= (D_W'(1) << QF) + D_W'(pzsum >> QF);
			zz_s3  <= ZZ_W'(z24 * z24);
			neg_s3 <= neg_s2;
		end
	end

	// Reciprocal t, then the polynomial, then exp(-z*z).
	logic              rc_valid;
	logic [T_W-1:0]    rc_t;
	logic [ZZ_W:0]     rc_side;
	logic              pl_valid;
	logic [PA_W-1:0]   pl_acc;
	logic [ZZ_W:0]     pl_side;
	logic              ex_valid;
	logic [E_W-1:0]    ex_e;
	logic [PA_W:0]     ex_side;

	cdf_recip #(
		.SIDE_W (ZZ_W + 1)
	) u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.d         (d_s3),
		.in_side   ({neg_s3, zz_s3}),
		.out_valid (rc_valid),
		.t         (rc_t),
		.out_side  (rc_side)
	);

	cdf_poly #(
		.SIDE_W (ZZ_W + 1)
	) u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (rc_valid),
		.t         (rc_t),
		.in_side   (rc_side),
		.out_valid (pl_valid),
		.acc       (pl_acc),
		.out_side  (pl_side)
	);

	cdf_exp #(
		.SIDE_W (PA_W + 1)
	) u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pl_valid),
		.zz        (pl_side[ZZ_W-1:0]),
		.in_side   ({pl_side[ZZ_W], pl_acc}),
		.out_valid (ex_valid),
		.e         (ex_e),
		.out_side  (ex_side)
	);

	// Back stage 4: product of the polynomial and the exponential.
	logic            v_s4;
	logic [MP_W-1:0] mp_s4;
	logic            neg_s4;

	// Back stage 5: y, then v, the probability in Q31, output rounding and saturation.
	logic [MP_W-1:0]        mpsum;
	logic [MP_W-1:0]        m;
	logic [E_W-1:0]         y;
	logic [31:0]            v;
	logic [31:0]            qs;
	logic                   v_s5;
	logic [OUTPUT_BITS-1:0] prob_s5;

	assign mpsum = mp_s4 + MP_W'(RND_Q);
	assign m     = mpsum >> QF;
	assign y     = (m >= MP_W'(ONE_Q)) ? '0 : ONE_Q - E_W'(m);
	assign v     = neg_s4 ? 32'(ONE_Q) - 32'(y) : 32'(ONE_Q) + 32'(y);
	assign qs    = (v + (32'd1 << (30 - OUTPUT_BITS))) >> (31 - OUTPUT_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= ex_valid;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mp_s4   <= MP_W'(ex_side[PA_W-1:0] * ex_e);
			neg_s4  <= ex_side[PA_W];
			prob_s5 <= (qs > TOP_CODE) ? OUTPUT_BITS'(TOP_CODE) : OUTPUT_BITS'(qs);
		end
	end

	// The pipeline moves whenever the output register can take a new item.
	assign en                 = !v_s5 || result.ready;
	assign sample.ready       = en;
	assign result.valid       = v_s5;
	assign result.probability = prob_s5;

`ifndef SYNTH
	// A negative score never yields more than one half.
	a_neg_half: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s4 && neg_s4) |=> (32'(prob_s5) <= HALF_CODE))
		else $error("negative score gave a probability above one half");

	// A non-negative score never yields less than one half.
	a_pos_half: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s4 && !neg_s4) |=> (32'(prob_s5) >= HALF_CODE))
		else $error("non-negative score gave a probability below one half");

	// The reciprocal lies in (1/3, 1] since d lies in [1, 3); checked against (1/4, 1].
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		rc_valid |-> (rc_t <= T_W'(ONE_Q) && rc_t > (T_W'(ONE_Q) >> 2)))
		else $error("reciprocal out of range");

	// The exponential never exceeds one.
	a_e_range: assert property (@(posedge clk) disable iff (!arst_n)
		ex_valid |-> (ex_e <= ONE_Q))
		else $error("exponential above one");
`endif

endmodule

`default_nettype wire

// ===== src/cdf_recip.sv =====
// Pipelined restoring divider for t = (2^60 + d/2) / d, one quotient bit per stage.
// Depends on cdf_pkg.
`default_nettype none

module cdf_recip import cdf_pkg::*; #(
	parameter int SIDE_W = ZZ_W + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [D_W-1:0]    d,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [T_W-1:0]    t,
	output logic [SIDE_W-1:0] out_side
);

	localparam int STAGES = T_W;

	logic              vld_s  [STAGES];
	logic [D_W-1:0]    rem_s  [STAGES];
	logic [T_W-1:0]    quo_s  [STAGES];
	logic [T_W-1:0]    num_s  [STAGES];
	logic [D_W-1:0]    den_s  [STAGES];
	logic [SIDE_W-1:0] side_s [STAGES];

	for (genvar j = 0; j < STAGES; j++) begin : g_bit
		logic              vld_in;
		logic [D_W-1:0]    rem_in;
		logic [T_W-1:0]    quo_in;
		logic [T_W-1:0]    num_in;
		logic [D_W-1:0]    den_in;
		logic [SIDE_W-1:0] side_in;
		logic [D_W:0]      trial;
		logic [D_W:0]      diff;
		logic              fits;

		// The upper numerator bits are always 2^29; the low bits are d/2.
		if (j == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = D_W'(1) << (QF - 1);
			assign quo_in  = '0;
			assign num_in  = d[D_W-1:1];
			assign den_in  = d;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign quo_in  = quo_s[j-1];
			assign num_in  = num_s[j-1];
			assign den_in  = den_s[j-1];
			assign side_in = side_s[j-1];
		end

		// Shift in the next numerator bit and subtract where the divisor fits.
		assign trial = {rem_in, num_in[T_W-1-j]};
		assign diff  = trial - {1'b0, den_in};
		assign fits  = trial >= {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
				quo_s[j]  <= quo_in | (T_W'(fits) << (T_W - 1 - j));
				num_s[j]  <= num_in;
				den_s[j]  <= den_in;
				side_s[j] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign t         = quo_s[STAGES-1];
	assign out_side  = side_s[STAGES-1];

endmodule

`default_nettype wire

// ===== src/cdf_poly.sv =====
// Horner evaluation of the fourth-order polynomial in t, times t, clamped at zero.
// Each step is a multiply stage and a round-and-add stage. Depends on cdf_pkg.
`default_nettype none

module cdf_poly import cdf_pkg::*; #(
	parameter int SIDE_W = ZZ_W + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [T_W-1:0]    t,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [PA_W-1:0]   acc,
	output logic [SIDE_W-1:0] out_side
);

	localparam int MAGW   = ACC_W - 1;
	localparam int PROD_W = MAGW + T_W;

	logic                    mv_s    [POLY_STEPS];
	logic [PROD_W-1:0]       prod_s  [POLY_STEPS];
	logic                    psg_s   [POLY_STEPS];
	logic [T_W-1:0]          pt_s    [POLY_STEPS];
	logic [SIDE_W-1:0]       pside_s [POLY_STEPS];
	logic                    av_s    [POLY_STEPS];
	logic signed [ACC_W-1:0] acc_s   [POLY_STEPS];
	logic [T_W-1:0]          at_s    [POLY_STEPS];
	logic [SIDE_W-1:0]       aside_s [POLY_STEPS];

	for (genvar j = 0; j < POLY_STEPS; j++) begin : g_step
		logic                    vld_in;
		logic signed [ACC_W-1:0] acc_in;
		logic [T_W-1:0]          t_in;
		logic [SIDE_W-1:0]       side_in;
		logic [MAGW-1:0]         mag;
		logic [PROD_W-1:0]       psum;
		logic [ACC_W-1:0]        rnd;
		logic signed [ACC_W:0]   val;
		logic signed [ACC_W:0]   nxt;

		if (j == 0) begin : g_first
			assign vld_in  = in_valid;
			assign acc_in  = POLY_A5;
			assign t_in    = t;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = av_s[j-1];
			assign acc_in  = acc_s[j-1];
			assign t_in    = at_s[j-1];
			assign side_in = aside_s[j-1];
		end

		// Multiply the magnitude; the sign is put back after rounding.
		assign mag = acc_in[ACC_W-1] ? MAGW'(-acc_in) : MAGW'(acc_in);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mv_s[j] <= 1'b0;
				av_s[j] <= 1'b0;
			end else if (en) begin
				mv_s[j] <= vld_in;
				av_s[j] <= mv_s[j];
			end
		end

		// Round to nearest, restore the sign, add the next coefficient.
		assign psum = prod_s[j] + PROD_W'(RND_Q);
		assign rnd  = ACC_W'(psum >> QF);
		assign val  = psg_s[j] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
		assign nxt  = val + POLY_ADD[j];

		always_ff @(posedge clk) begin
			if (en) begin
				prod_s[j]  <= PROD_W'(mag * t_in);
				psg_s[j]   <= acc_in[ACC_W-1];
				pt_s[j]    <= t_in;
				pside_s[j] <= side_in;
				if (j == POLY_STEPS - 1 && nxt < 0) begin
					acc_s[j] <= '0;
				end else begin
					acc_s[j] <= ACC_W'(nxt);
				end
				at_s[j]    <= pt_s[j];
				aside_s[j] <= pside_s[j];
			end
		end
	end

	assign out_valid = av_s[POLY_STEPS-1];
	assign acc       = PA_W'(acc_s[POLY_STEPS-1]);
	assign out_side  = aside_s[POLY_STEPS-1];

endmodule

`default_nettype wire

// ===== src/cdf_exp.sv =====
// exp(-w) for w = z*z: w/32 through a degree-ten Taylor series in Horner form,
// then squared five times. Depends on cdf_pkg.
`default_nettype none

module cdf_exp import cdf_pkg::*; #(
	parameter int SIDE_W = PA_W + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [ZZ_W-1:0]   zz,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [E_W-1:0]    e,
	output logic [SIDE_W-1:0] out_side
);

	localparam int W_W    = ZZ_W - 18 + 1;
	localparam int SB_W   = SIDE_W + 1;
	localparam int GP_W   = G_W + E_W;
	localparam int PM_W   = E_W + 33;
	localparam int RK_W   = E_W + 4;
	localparam int SQ_W   = 2 * E_W;
	localparam logic [W_W-1:0] W_ZERO = W_W'(37'h5_8000_0000);

	// Argument stage: w in Q30, the cut-off flag and g = w/32.
	logic [ZZ_W:0]   zsum;
	logic [W_W-1:0]  w;
	logic [W_W-1:0]  wsum;
	logic            v_s1;
	logic [G_W-1:0]  g_s1;
	logic [SB_W-1:0] sb_s1;

	assign zsum = {1'b0, zz} + (ZZ_W + 1)'(1 << 17);
	assign w    = W_W'(zsum >> 18);
	assign wsum = w + W_W'(16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1  <= G_W'(wsum >> 5);
			sb_s1 <= {w >= W_ZERO, in_side};
		end
	end

	// Taylor steps: multiply, round and scale by 1/k, correct and subtract.
	logic            ta_v  [TAYLOR_TERMS];
	logic [GP_W-1:0] ta_p  [TAYLOR_TERMS];
	logic [G_W-1:0]  ta_g  [TAYLOR_TERMS];
	logic [SB_W-1:0] ta_sb [TAYLOR_TERMS];
	logic            tb_v  [TAYLOR_TERMS];
	logic [E_W-1:0]  tb_n  [TAYLOR_TERMS];
	logic [PM_W-1:0] tb_pm [TAYLOR_TERMS];
	logic [G_W-1:0]  tb_g  [TAYLOR_TERMS];
	logic [SB_W-1:0] tb_sb [TAYLOR_TERMS];
	logic            tc_v  [TAYLOR_TERMS];
	logic [E_W-1:0]  tc_s  [TAYLOR_TERMS];
	logic [G_W-1:0]  tc_g  [TAYLOR_TERMS];
	logic [SB_W-1:0] tc_sb [TAYLOR_TERMS];

	for (genvar i = 0; i < TAYLOR_TERMS; i++) begin : g_term
		localparam int K = TAYLOR_TERMS - i;
		localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);

		logic            vld_in;
		logic [E_W-1:0]  s_in;
		logic [G_W-1:0]  g_in;
		logic [SB_W-1:0] sb_in;
		logic [GP_W-1:0] psum;
		logic [E_W-1:0]  term;
		logic [E_W-1:0]  num;
		logic [E_W-1:0]  qe;
		logic [RK_W-1:0] rem;
		logic [E_W-1:0]  quo;

		if (i == 0) begin : g_first
			assign vld_in = v_s1;
			assign s_in   = ONE_Q;
			assign g_in   = g_s1;
			assign sb_in  = sb_s1;
		end else begin : g_next
			assign vld_in = tc_v[i-1];
			assign s_in   = tc_s[i-1];
			assign g_in   = tc_g[i-1];
			assign sb_in  = tc_sb[i-1];
		end

		assign psum = ta_p[i] + GP_W'(RND_Q);
		assign term = E_W'(psum >> QF);
		assign num  = term + E_W'(K / 2);

		// The reciprocal estimate is low by at most one.
		assign qe   = E_W'(tb_pm[i] >> 32);
		assign rem  = {4'b0, tb_n[i]} - RK_W'({4'b0, qe} * RK_W'(K));
		assign quo  = qe + E_W'(rem >= RK_W'(K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ta_v[i] <= 1'b0;
				tb_v[i] <= 1'b0;
				tc_v[i] <= 1'b0;
			end else if (en) begin
				ta_v[i] <= vld_in;
				tb_v[i] <= ta_v[i];
				tc_v[i] <= tb_v[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ta_p[i]  <= GP_W'(g_in * s_in);
				ta_g[i]  <= g_in;
				ta_sb[i] <= sb_in;
				tb_n[i]  <= num;
				tb_pm[i] <= PM_W'(num * RECIP);
				tb_g[i]  <= ta_g[i];
				tb_sb[i] <= ta_sb[i];
				tc_s[i]  <= (quo >= ONE_Q) ? '0 : ONE_Q - quo;
				tc_g[i]  <= tb_g[i];
				tc_sb[i] <= tb_sb[i];
			end
		end
	end

	// Squarings: round the previous square, then square again.
	logic            sq_v  [SQUARINGS];
	logic [SQ_W-1:0] sq_p  [SQUARINGS];
	logic [SB_W-1:0] sq_sb [SQUARINGS];

	for (genvar j = 0; j < SQUARINGS; j++) begin : g_sq
		logic            vld_in;
		logic [E_W-1:0]  e_in;
		logic [SB_W-1:0] sb_in;

		if (j == 0) begin : g_first
			assign vld_in = tc_v[TAYLOR_TERMS-1];
			assign e_in   = tc_s[TAYLOR_TERMS-1];
			assign sb_in  = tc_sb[TAYLOR_TERMS-1];
		end else begin : g_next
			logic [SQ_W-1:0] psum;

			assign vld_in = sq_v[j-1];
			assign psum   = sq_p[j-1] + SQ_W'(RND_Q);
			assign e_in   = E_W'(psum >> QF);
			assign sb_in  = sq_sb[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[j] <= 1'b0;
			end else if (en) begin
				sq_v[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_p[j]  <= SQ_W'(e_in * e_in);
				sq_sb[j] <= sb_in;
			end
		end
	end

	// Last rounding; the cut-off flag forces zero.
	logic [SQ_W-1:0] fsum;
	logic            v_sf;
	logic [E_W-1:0]  e_sf;
	logic [SIDE_W-1:0] side_sf;

	assign fsum = sq_p[SQUARINGS-1] + SQ_W'(RND_Q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (en) begin
			v_sf <= sq_v[SQUARINGS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_sf    <= sq_sb[SQUARINGS-1][SB_W-1] ? '0 : E_W'(fsum >> QF);
			side_sf <= sq_sb[SQUARINGS-1][SIDE_W-1:0];
		end
	end

	assign out_valid = v_sf;
	assign e         = e_sf;
	assign out_side  = side_sf;

endmodule

`default_nettype wire
